// ===== hdl/sab_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the suffix array builder.
// Used by sab_ctrl, sab_datapath and suffix_array_builder; no dependencies.
package sab_pkg;

  localparam int CH_W     = 8;  // character width
  localparam int POS_W    = 6;  // position field width
  localparam int S_DATA_W = 8;  // input tdata width
  localparam int M_DATA_W = 8;  // output tdata width

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;      // store the incoming character
    logic build_clr; // clear i, j and the rank count
    logic j_inc;     // move to the next comparison partner
    logic cnt_inc;   // partner suffix is smaller than suffix i
    logic ord_wr;    // write i at its slot, advance i, restart j
    logic t_clr;     // restart the character offset
    logic t_inc;     // advance the character offset
    logic rd_txt;    // read both characters at the current offset
    logic r_clr;     // restart the output index
    logic r_inc;     // advance the output index
    logic rd_ord;    // read the order store at the output index
    logic len_clr;   // empty the string store
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic j_done;    // all partners visited
    logic j_eq_i;    // partner is suffix i itself
    logic i_last;    // suffix i is the last one
    logic decided;   // the pair comparison is settled
    logic greater;   // suffix i is larger than the partner
    logic r_last;    // output index is on the last slot
  } sts_t;

endpackage

// ===== hdl/sab_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the suffix array builder: string store, order store, counters
// and the character comparator. Depends on sab_pkg.
module sab_datapath #(
  parameter int MAX_LEN = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sab_pkg::cmd_t        cmd,
  input  logic [sab_pkg::CH_W-1:0] ch,
  output sab_pkg::sts_t        sts,
  output logic [sab_pkg::POS_W-1:0] position,
  output logic                 final_res
);

  localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W  = $clog2(MAX_LEN + 1);

  logic [sab_pkg::CH_W-1:0] text_mem [MAX_LEN];
  logic [ADDR_W-1:0]        order_mem [MAX_LEN];

  logic [CNT_W-1:0] len;
  logic [CNT_W-1:0] i;
  logic [CNT_W-1:0] j;
  logic [CNT_W-1:0] t;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] r;
  logic [sab_pkg::CH_W-1:0] ch_i;
  logic [sab_pkg::CH_W-1:0] ch_j;
  logic [ADDR_W-1:0]        ord_q;

  logic [CNT_W:0] addr_i;
  logic [CNT_W:0] addr_j;
  logic           end_i;
  logic           end_j;

  assign addr_i = {1'b0, i} + {1'b0, t};
  assign addr_j = {1'b0, j} + {1'b0, t};
  assign end_i  = (addr_i >= {1'b0, len});
  assign end_j  = (addr_j >= {1'b0, len});

  // Control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
      i   <= '0;
      j   <= '0;
      t   <= '0;
      cnt <= '0;
      r   <= '0;
    end else begin
      if (cmd.len_clr) begin
        len <= '0;
      end else if (cmd.take && (len < CNT_W'(MAX_LEN))) begin
        len <= len + 1'b1;
      end
      if (cmd.build_clr) begin
        i   <= '0;
        j   <= '0;
        cnt <= '0;
      end else if (cmd.ord_wr) begin
        i   <= i + 1'b1;
        j   <= '0;
        cnt <= '0;
      end else begin
        if (cmd.j_inc)   j   <= j + 1'b1;
        if (cmd.cnt_inc) cnt <= cnt + 1'b1;
      end
      if (cmd.t_clr) begin
        t <= '0;
      end else if (cmd.t_inc) begin
        t <= t + 1'b1;
      end
      if (cmd.r_clr) begin
        r <= '0;
      end else if (cmd.r_inc) begin
        r <= r + 1'b1;
      end
    end
  end

  // String store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.take && (len < CNT_W'(MAX_LEN))) begin
      text_mem[len[ADDR_W-1:0]] <= ch;
    end
    if (cmd.rd_txt) begin
      ch_i <= text_mem[addr_i[ADDR_W-1:0]];
      ch_j <= text_mem[addr_j[ADDR_W-1:0]];
    end
  end

  // Order store: slot = number of smaller suffixes
  always_ff @(posedge clk) begin
    if (cmd.ord_wr) begin
      order_mem[cnt[ADDR_W-1:0]] <= i[ADDR_W-1:0];
    end
    if (cmd.rd_ord) begin
      ord_q <= order_mem[r[ADDR_W-1:0]];
    end
  end

  // Comparison of suffix i against suffix j at offset t; end sorts lowest
  always_comb begin
    sts.j_done  = (j == len);
    sts.j_eq_i  = (j == i);
    sts.i_last  = (i == len - 1'b1);
    sts.decided = end_i || end_j || (ch_i != ch_j);
    sts.greater = !end_i && (end_j || (ch_i > ch_j));
    sts.r_last  = (r == len - 1'b1);
  end

  assign position  = sab_pkg::POS_W'(ord_q);
  assign final_res = sts.r_last;

endmodule

// ===== hdl/sab_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the suffix array builder: sequences loading, ranking of
// every suffix by pairwise comparison, and emission. Depends on sab_pkg.
module sab_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_fire,
  input  logic          in_last,
  input  logic          out_ready,
  input  sab_pkg::sts_t sts,
  output sab_pkg::cmd_t cmd,
  output logic          in_ready,
  output logic          out_valid
);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_PAIR = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_ERD  = 3'd4;
  localparam logic [2:0] S_EOUT = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_LOAD: begin
        cmd.take = in_fire;
        if (in_fire && in_last) begin
          cmd.build_clr = 1'b1;
          state_next    = S_PAIR;
        end
      end
      S_PAIR: begin
        if (sts.j_done) begin
          cmd.ord_wr = 1'b1;
          if (sts.i_last) begin
            cmd.r_clr  = 1'b1;
            state_next = S_ERD;
          end
        end else if (sts.j_eq_i) begin
          cmd.j_inc = 1'b1;
        end else begin
          cmd.t_clr  = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_txt = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (sts.decided) begin
          cmd.j_inc   = 1'b1;
          cmd.cnt_inc = sts.greater;
          state_next  = S_PAIR;
        end else begin
          cmd.t_inc  = 1'b1;
          state_next = S_RD;
        end
      end
      S_ERD: begin
        cmd.rd_ord = 1'b1;
        state_next = S_EOUT;
      end
      S_EOUT: begin
        if (out_ready) begin
          if (sts.r_last) begin
            cmd.len_clr = 1'b1;
            state_next  = S_LOAD;
          end else begin
            cmd.r_inc  = 1'b1;
            state_next = S_ERD;
          end
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  assign in_ready  = (state == S_LOAD);
  assign out_valid = (state == S_EOUT);

endmodule

// ===== hdl/suffix_array_builder.sv =====
`timescale 1ns / 1ps
// Top level of the suffix array builder: controller plus datapath.
// Depends on sab_pkg, sab_ctrl and sab_datapath.
//
//  channel | dir | tdata                 | tlast
//  s_*     | in  | [7:0] ch              | last character of the string
//  m_*     | out | [5:0] position, 0 pad | final position of the array
//
// Loading takes one character per cycle. After the flagged character, each
// suffix i is ranked by comparing it with every other suffix, one character
// at a time (registered string store read, then compare); the work grows
// with the common prefixes and is largest when all characters are equal.
// Emission reads each position from the order store, then offers it and
// holds it through any output stall; no input is taken from the flagged
// character until the last position is delivered.
// Reset is synchronous and clears only control state.
module suffix_array_builder #(
  parameter int MAX_LEN = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [sab_pkg::S_DATA_W-1:0] s_tdata,  // [7:0] ch
  input  logic                         s_tlast,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [sab_pkg::M_DATA_W-1:0] m_tdata,  // [5:0] position, [7:6] zero
  output logic                         m_tlast
);

  sab_pkg::cmd_t cmd;
  sab_pkg::sts_t sts;
  logic          in_fire;
  logic [sab_pkg::POS_W-1:0] position;

  assign in_fire = s_tvalid && s_tready;

  sab_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_last   (s_tlast),
    .out_ready (m_tready),
    .sts       (sts),
    .cmd       (cmd),
    .in_ready  (s_tready),
    .out_valid (m_tvalid)
  );

  sab_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ch        (s_tdata[sab_pkg::CH_W-1:0]),
    .sts       (sts),
    .position  (position),
    .final_res (m_tlast)
  );

  assign m_tdata = {{(sab_pkg::M_DATA_W - sab_pkg::POS_W){1'b0}}, position};

  // Loading and emission never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input ready while emitting");

  // A flagged character closes loading
  a_last_stops_input: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> !s_tready)
    else $error("input still ready after last character");

  // The final position returns the block to loading
  a_final_reloads: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
    else $error("not back to loading after final position");

endmodule
